FILE: rtl/pinv_pkg.sv
// Package for the pseudo-inverse block: field widths, store size, item kinds and register indexes.
// No dependencies.
`default_nettype none
package pinv_pkg;
    localparam int unsigned ValueW = 32;
    localparam int unsigned IndexW = 6;
    localparam int unsigned KindW  = 2;
    localparam int unsigned SizeW  = 7;
    localparam int unsigned CutW   = 31;

    // Largest matrix dimension the stores hold; the index ports are sized for it.
    localparam int unsigned MaxSize = 64;

    localparam logic [KindW-1:0] KIND_VEC   = 2'd0;
    localparam logic [KindW-1:0] KIND_VAL   = 2'd1;
    localparam logic [KindW-1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] REG_SIZE   = 2'd0;
    localparam logic [1:0] REG_CUTOFF = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef logic signed [ValueW-1:0] t_value;
endpackage
`default_nettype wire

FILE: rtl/pinv_from_eigen_solution.sv
// Top level of the pseudo-inverse block: stores, sequencer, shared multiplier and divider.
// Depends on pinv_pkg.
//
// Channel   | Direction | Handshake        | Payload
// command   | in        | i_start / o_busy | i_kind, i_row, i_col, i_value
// result    | out       | o_valid (strobe) | o_entry, o_saturated
// config    | in        | APB psel/penable | paddr, pwdata, prdata
//
// A write beat leaves the block idle. A query stays busy through each eigenvalue in turn, and
// its result beat comes as busy drops. A rejected eigenvalue costs a store read and the
// cutoff test; a passing one adds the eigenvector reads and multiply, the restoring divider (one
// quotient bit per cycle, which sets the pace) and a step to accumulate. Out-of-range queries
// go straight to the final states. Reset is synchronous; the stores are undefined until written.
// The receiver cannot stall; the result strobe lasts one cycle.
`default_nettype none
module pinv_from_eigen_solution (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  wire  [1:0]          i_kind,
    input  wire  [5:0]          i_row,
    input  wire  [5:0]          i_col,
    input  wire  signed [31:0]  i_value,
    output logic                o_valid,
    output logic signed [31:0]  o_entry,
    output logic                o_saturated,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int unsigned MAX_SIZE = pinv_pkg::MaxSize;
    localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned KW = $clog2(MAX_SIZE + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_RDE = 4'd1, S_CHK = 4'd2, S_RDI = 4'd3,
                           S_RDJ = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_ACC = 4'd7,
                           S_FIN = 4'd8, S_OUT = 4'd9;

    localparam logic [1:0] REG_SIZE_C = pinv_pkg::REG_SIZE;
    localparam logic [1:0] REG_CUT_C  = pinv_pkg::REG_CUTOFF;
    localparam logic [1:0] REG_MODE_C = pinv_pkg::REG_MODE;

    // Stores.
    logic signed [31:0] vec_mem [MAX_SIZE*MAX_SIZE];
    logic signed [31:0] val_mem [MAX_SIZE];
    logic signed [31:0] r_vec_q, r_val_q;
    logic [2*AW-1:0]    vec_raddr;
    logic [AW-1:0]      val_raddr;

    // Configuration registers.
    logic [6:0]  r_size;
    logic [30:0] r_cutoff;
    logic        r_mode;

    // Sequencer state.
    logic [3:0]  r_state, n_state;
    logic [5:0]  r_row, r_col;
    logic [KW-1:0] r_k, r_n;
    logic signed [31:0] r_e, r_vi;
    logic signed [63:0] r_p;
    logic signed [63:0] r_acc;
    logic [6:0]  r_cnt;
    logic [63:0] r_quo, r_rem;
    logic [40:0] r_dvs;
    logic        r_neg;
    logic        r_valid;
    logic signed [31:0] r_entry;
    logic        r_sat;

    logic        acc_beat, wr_beat;
    logic [6:0]  size_eff;
    logic [AW-1:0] k_idx;
    logic signed [32:0] e_mag;
    logic        pass;
    logic [64:0] trial;
    logic signed [63:0] term, acc_div;

    assign pready   = 1'b1;
    assign wr_beat  = psel & penable & pwrite;
    assign acc_beat = i_start & ~o_busy;
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_entry  = r_entry;
    assign o_saturated = r_sat;
    assign k_idx    = r_k[AW-1:0];

    always_comb begin
        size_eff = (r_size > 7'(MAX_SIZE)) ? 7'(MAX_SIZE) : r_size;
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_SIZE_C:   prdata = {25'd0, r_size};
            REG_CUT_C:    prdata = {1'b0, r_cutoff};
            REG_MODE_C:   prdata = {31'd0, r_mode};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 7'd64; r_cutoff <= '0; r_mode <= 1'b0;
        end else if (wr_beat) begin
            if (paddr[3:2] == REG_SIZE_C) r_size <= pwdata[6:0];
            if (paddr[3:2] == REG_CUT_C)  r_cutoff <= pwdata[30:0];
            if (paddr[3:2] == REG_MODE_C) r_mode <= pwdata[0];
        end
    end

    // Store writes; indexes are in range only when they fit in MAX_SIZE.
    always_ff @(posedge i_clk) begin
        if (acc_beat && i_kind == pinv_pkg::KIND_VEC &&
            32'(i_row) < MAX_SIZE && 32'(i_col) < MAX_SIZE)
            vec_mem[{i_row[AW-1:0], i_col[AW-1:0]}] <= i_value;
        if (acc_beat && i_kind == pinv_pkg::KIND_VAL && 32'(i_col) < MAX_SIZE)
            val_mem[i_col[AW-1:0]] <= i_value;
    end

    // Registered store reads.
    always_comb begin
        vec_raddr = (r_state == S_CHK) ? {r_row[AW-1:0], k_idx} : {r_col[AW-1:0], k_idx};
        val_raddr = k_idx;
    end
    always_ff @(posedge i_clk) begin
        r_vec_q <= vec_mem[vec_raddr];
        r_val_q <= val_mem[val_raddr];
    end

    // Cutoff test on the eigenvalue just read from the store.
    always_comb begin
        e_mag = (!r_mode && r_val_q[31]) ? -33'(r_val_q) : 33'(r_val_q);
        pass  = e_mag > $signed({2'b00, r_cutoff});
    end

    // One restoring division step: |P| / (|e|*256).
    always_comb begin
        trial = {r_rem, r_quo[63]} - {24'd0, r_dvs};
    end
    assign term    = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign acc_div = r_acc / 64'sd256;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc_beat && i_kind == pinv_pkg::KIND_QUERY)
                        n_state = (7'(i_row) >= size_eff || 7'(i_col) >= size_eff) ?
                                  S_FIN : (size_eff == 7'd0 ? S_FIN : S_RDE);
            S_RDE:  n_state = S_CHK;
            S_CHK:  n_state = pass ? S_RDI : ((r_k + 1'b1 == r_n) ? S_FIN : S_RDE);
            S_RDI:  n_state = S_RDJ;
            S_RDJ:  n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (r_cnt == 7'd63) n_state = S_ACC;
            S_ACC:  n_state = (r_k + 1'b1 == r_n) ? S_FIN : S_RDE;
            S_FIN:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
        end
    end

    // Datapath under the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_row <= i_row; r_col <= i_col;
                r_n   <= KW'(size_eff);
                r_k   <= '0;
                r_acc <= '0;
            end
            S_RDE: ;
            S_CHK: begin
                r_e <= r_val_q;
                if (!pass && !(r_k + 1'b1 == r_n)) r_k <= r_k + 1'b1;
            end
            S_RDI: r_vi <= r_vec_q;
            S_RDJ: r_p  <= 64'(r_vi) * 64'(r_vec_q);
            S_MUL: begin
                r_neg <= r_p[63] ^ r_e[31];
                r_quo <= r_p[63] ? 64'(-r_p) : 64'(r_p);
                r_rem <= '0;
                r_dvs <= {(r_e[31] ? 33'(-33'(r_e)) : 33'(r_e)), 8'd0};
                r_cnt <= '0;
            end
            S_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (!trial[64]) begin
                    r_rem <= trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], r_quo[63]};
                    r_quo <= {r_quo[62:0], 1'b0};
                end
            end
            S_ACC: begin
                r_acc <= r_acc + term;
                r_k   <= r_k + 1'b1;
            end
            S_FIN: ;
            S_OUT: begin
                if (acc_div > 64'sd2147483647) begin
                    r_entry <= 32'sh7fffffff; r_sat <= 1'b1;
                end else if (acc_div < -64'sd2147483648) begin
                    r_entry <= 32'sh80000000; r_sat <= 1'b1;
                end else begin
                    r_entry <= acc_div[31:0]; r_sat <= 1'b0;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/pinv_checker.sv
// Port checker for the pseudo-inverse block, bound to the top level.
// Depends on pinv_from_eigen_solution's ports only.
`default_nettype none
module pinv_checker (
    input wire i_clk, input wire i_rst_n, input wire o_busy,
    input wire o_valid, input wire o_saturated, input wire signed [31:0] o_entry
);
    // A result beat is never shown back to back.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    // A result ends the busy period.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("busy with result");
    // Saturation shows only a clamped value.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_entry == 32'sh7fffffff || o_entry == 32'sh80000000))
        else $error("bad clamp");
    // Reset leaves the block idle.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> (!o_busy && !o_valid))
        else $error("not idle after reset");
endmodule
bind pinv_from_eigen_solution pinv_checker u_chk (.*);
`default_nettype wire

FILE: sim/pinv_from_eigen_solution_test.sv
// Testbench for the pseudo-inverse block: loads eigenvectors and eigenvalues, queries entries
// and checks each result against an in-bench predictor. Depends on pinv_pkg and the DUT.
`timescale 1ns / 1ps
module pinv_from_eigen_solution_test;
    localparam logic [pinv_pkg::KindW-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned MaxSize = pinv_pkg::MaxSize;
    // Queries that fall in range keep to the first rows, so only those rows are filled in full.
    localparam int unsigned FillRows = 8;

    typedef struct {
        pinv_pkg::t_value entry;
        logic             saturated;
    } t_pinv_entry;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic [pinv_pkg::KindW-1:0]   i_kind = '0;
    logic [pinv_pkg::IndexW-1:0]  i_row = '0;
    logic [pinv_pkg::IndexW-1:0]  i_col = '0;
    logic signed [31:0]           i_value = '0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [3:0]                   paddr = '0;
    logic [31:0]                  pwdata = '0;
    wire                          o_busy;
    wire                          o_valid;
    wire signed [31:0]            o_entry;
    wire                          o_saturated;
    wire [31:0]                   prdata;
    wire                          pready;

    pinv_from_eigen_solution dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_kind(i_kind), .i_row(i_row), .i_col(i_col), .i_value(i_value),
        .o_valid(o_valid), .o_entry(o_entry), .o_saturated(o_saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: stores, written flags and register copies.
    pinv_pkg::t_value            vec_mem [MaxSize*MaxSize];
    pinv_pkg::t_value            eig_mem [MaxSize];
    bit                          vec_written [MaxSize*MaxSize];
    bit                          eig_written [MaxSize];
    logic [pinv_pkg::SizeW-1:0]  size_reg = 7'd64;
    logic [pinv_pkg::CutW-1:0]   cutoff_reg = '0;
    logic                        mode_reg = 1'b0;

    t_pinv_entry       pending_entries[$];
    int                error_count = 0;
    int                items_sent = 0;
    int                queries_sent = 0;
    int                entries_seen = 0;
    int                saturated_seen = 0;
    int                idle_pct = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Works out the pseudo-inverse entry for one query from the stored eigen-solution.
    function automatic t_pinv_entry pinv_entry_of(logic [5:0] row, logic [5:0] col);
        t_pinv_entry r;
        int unsigned n;
        longint acc, mag, prod, den, sum;
        pinv_pkg::t_value e;
        n = (size_reg > MaxSize) ? MaxSize : size_reg;
        r.entry = '0;
        r.saturated = 1'b0;
        acc = 0;
        if (row >= n || col >= n) return r;
        for (int k = 0; k < n; k++) begin
            e = eig_mem[k];
            mag = longint'(e);
            if (!mode_reg && mag < 0) mag = -mag;
            if (mag > longint'(cutoff_reg)) begin
                prod = longint'(vec_mem[{row, 6'(k)}]) * longint'(vec_mem[{col, 6'(k)}]);
                den = longint'(e) * 256;
                acc += prod / den;
            end
        end
        sum = acc / 256;
        if (sum > 64'sd2147483647) begin
            r.entry = 32'sh7fffffff;
            r.saturated = 1'b1;
        end else if (sum < -64'sd2147483648) begin
            r.entry = 32'sh80000000;
            r.saturated = 1'b1;
        end else begin
            r.entry = pinv_pkg::t_value'(sum);
        end
        return r;
    endfunction

    // Sends one beat and updates the predictor once the block takes it.
    task automatic send_item(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
                             logic [31:0] value);
        @(negedge i_clk);
        i_start = 1'b1;
        i_kind = kind;
        i_row = row;
        i_col = col;
        i_value = value;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        items_sent++;
        case (kind)
            pinv_pkg::KIND_VEC: begin
                vec_mem[{row, col}] = value;
                vec_written[{row, col}] = 1'b1;
            end
            pinv_pkg::KIND_VAL: begin
                eig_mem[col] = value;
                eig_written[col] = 1'b1;
            end
            pinv_pkg::KIND_QUERY: begin
                pending_entries.push_back(pinv_entry_of(row, col));
                queries_sent++;
            end
            default: ;
        endcase
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end
    endtask

    // Waits until every query has answered and the block has settled.
    task automatic wait_idle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes a register over APB and reads it back.
    task automatic set_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] want;
        wait_idle();
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        case (idx)
            pinv_pkg::REG_SIZE: begin
                size_reg = value[pinv_pkg::SizeW-1:0]; want = 32'(size_reg);
            end
            pinv_pkg::REG_CUTOFF: begin
                cutoff_reg = value[pinv_pkg::CutW-1:0]; want = 32'(cutoff_reg);
            end
            default: begin mode_reg = value[0]; want = 32'(mode_reg); end
        endcase
        @(negedge i_clk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($urandom_range(0, 2 ** 17)) - 32'd65536;
            2: return 32'($urandom_range(0, 2 ** 25)) - 32'd16777216;
            3: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
            default: return $signed(32'($urandom_range(0, 2 ** 26))) - 32'sd33554432;
        endcase
    endfunction

    // An index beyond the size in use where there is one, else one of the loaded rows.
    function automatic logic [5:0] far_index(int unsigned n, int unsigned lim);
        if (n < MaxSize) return 6'($urandom_range(n, MaxSize - 1));
        return 6'($urandom_range(0, lim - 1));
    endfunction

    // Writes every eigenvalue and every entry of the loaded rows that a query at the
    // current size could read, where still unwritten.
    task automatic fill_block();
        int unsigned n, rows;
        n = (size_reg > MaxSize) ? MaxSize : size_reg;
        rows = (n < FillRows) ? n : FillRows;
        for (int c = 0; c < n; c++)
            if (!eig_written[c])
                send_item(pinv_pkg::KIND_VAL, 6'($urandom), 6'(c), random_value());
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < n; c++)
                if (!vec_written[{6'(r), 6'(c)}])
                    send_item(pinv_pkg::KIND_VEC, 6'(r), 6'(c), random_value());
    endtask

    // Compares each result beat with the oldest expected entry.
    always @(posedge i_clk) begin
        t_pinv_entry want;
        if (i_rst_n && o_valid) begin
            entries_seen++;
            if (pending_entries.size() == 0) begin
                report_mismatch("unexpected result entry", o_entry, 0);
            end else begin
                want = pending_entries.pop_front();
                if (want.saturated) saturated_seen++;
                if (o_entry !== want.entry) report_mismatch("entry", o_entry, want.entry);
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", o_saturated, want.saturated);
            end
        end
    end

    // Value extremes, both compare modes, out-of-range and ignored beats; sizes 4, 0, 127, 1.
    task automatic test_directed();
        set_reg(pinv_pkg::REG_SIZE, 32'd4);
        send_item(pinv_pkg::KIND_VAL, 6'd0, 6'd0, 32'h00010000);
        send_item(pinv_pkg::KIND_VAL, 6'd0, 6'd1, 32'hffff0000);
        send_item(pinv_pkg::KIND_VAL, 6'd0, 6'd2, 32'h00000000);
        send_item(pinv_pkg::KIND_VAL, 6'd0, 6'd3, 32'h80000000);
        fill_block();
        send_item(pinv_pkg::KIND_VEC, 6'd0, 6'd0, 32'h7fffffff);
        send_item(pinv_pkg::KIND_VEC, 6'd1, 6'd0, 32'h80000000);
        send_item(pinv_pkg::KIND_VEC, 6'd63, 6'd63, 32'hffffffff);
        send_item(pinv_pkg::KIND_QUERY, 6'd0, 6'd0, 32'h0);
        send_item(pinv_pkg::KIND_QUERY, 6'd0, 6'd1, 32'hffffffff);
        send_item(pinv_pkg::KIND_QUERY, 6'd63, 6'd0, 32'h0);
        send_item(pinv_pkg::KIND_QUERY, 6'd0, 6'd4, 32'h0);
        send_item(KIND_UNUSED, 6'd0, 6'd0, 32'h12345678);
        // A tiny eigenvalue drives the sum far beyond the range.
        send_item(pinv_pkg::KIND_VAL, 6'd0, 6'd0, 32'h00000001);
        send_item(pinv_pkg::KIND_QUERY, 6'd0, 6'd0, 32'h0);
        send_item(pinv_pkg::KIND_QUERY, 6'd0, 6'd1, 32'h0);
        set_reg(pinv_pkg::REG_MODE, 32'd1);
        send_item(pinv_pkg::KIND_QUERY, 6'd1, 6'd1, 32'h0);
        set_reg(pinv_pkg::REG_CUTOFF, 32'h7fffffff);
        send_item(pinv_pkg::KIND_QUERY, 6'd2, 6'd3, 32'h0);
        set_reg(pinv_pkg::REG_MODE, 32'd0);
        send_item(pinv_pkg::KIND_QUERY, 6'd3, 6'd3, 32'h0);
        set_reg(pinv_pkg::REG_CUTOFF, 32'h0);
        // Size zero leaves every query out of range.
        set_reg(pinv_pkg::REG_SIZE, 32'd0);
        send_item(pinv_pkg::KIND_QUERY, 6'd0, 6'd0, 32'h0);
        // Size above the maximum acts as the maximum.
        set_reg(pinv_pkg::REG_SIZE, 32'd127);
        fill_block();
        send_item(pinv_pkg::KIND_QUERY, 6'd7, 6'd6, 32'h0);
        send_item(pinv_pkg::KIND_QUERY, 6'd5, 6'd2, 32'h0);
        set_reg(pinv_pkg::REG_SIZE, 32'd1);
        send_item(pinv_pkg::KIND_QUERY, 6'd0, 6'd0, 32'h0);
    endtask

    // Random setting of the three registers, mostly small sizes since queries are slow.
    task automatic new_setting();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) set_reg(pinv_pkg::REG_SIZE, 32'($urandom_range(64, 127)));
        else if (pick < 20) set_reg(pinv_pkg::REG_SIZE, 32'($urandom_range(9, 16)));
        else set_reg(pinv_pkg::REG_SIZE, 32'($urandom_range(1, 8)));
        case ($urandom_range(3))
            0: set_reg(pinv_pkg::REG_CUTOFF, 32'h0);
            1: set_reg(pinv_pkg::REG_CUTOFF, 32'($urandom_range(0, 2 ** 18)));
            2: set_reg(pinv_pkg::REG_CUTOFF, 32'($urandom_range(0, 2 ** 26)));
            default: set_reg(pinv_pkg::REG_CUTOFF, $urandom());
        endcase
        set_reg(pinv_pkg::REG_MODE, 32'($urandom_range(1)));
        fill_block();
    endtask

    // Random beats in phases of differing sender gaps.
    task automatic test_random(int pct, int count);
        int unsigned n, lim, pick;
        logic [5:0] r, c;
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) new_setting();
            if (i == count / 2) wait_idle();
            n = (size_reg > MaxSize) ? MaxSize : size_reg;
            lim = (n < FillRows) ? n : FillRows;
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_item(pinv_pkg::KIND_VEC, 6'($urandom), 6'($urandom), random_value());
            end else if (pick < 55) begin
                send_item(pinv_pkg::KIND_VAL, 6'($urandom), 6'($urandom), random_value());
            end else if (pick < 95) begin
                r = ($urandom_range(99) < 85) ? 6'($urandom_range(0, lim - 1)) :
                                                far_index(n, lim);
                c = ($urandom_range(99) < 85) ? 6'($urandom_range(0, lim - 1)) :
                                                far_index(n, lim);
                send_item(pinv_pkg::KIND_QUERY, r, c, $urandom());
            end else begin
                send_item(KIND_UNUSED, 6'($urandom), 6'($urandom), $urandom());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(25, 330);
        test_random(57, 330);
        test_random(0, 340);
        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d beats with %0d queries; %0d entries checked, %0d saturated.",
                 items_sent, queries_sent, entries_seen, saturated_seen);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Ends a run that hangs.
    initial begin
        #200ms;
        $display("Timed out with %0d entries still pending.", pending_entries.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: sim.f
rtl/pinv_pkg.sv
rtl/pinv_from_eigen_solution.sv
rtl/pinv_checker.sv
sim/pinv_from_eigen_solution_test.sv
